// ===== sv/fmdc_pkg.sv =====
// Shared types and constants of the flow metered dose controller.
package fmdc_pkg;

    localparam int unsigned ALU_W = 40;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    localparam logic [1:0] CAUSE_TARGET  = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_ABORT   = 2'd2;

    localparam logic [2:0] CFG_PULSES_PER_LITRE = 3'd0;
    localparam logic [2:0] CFG_TARGET_OFFSET    = 3'd1;
    localparam logic [2:0] CFG_LITRES_PER_PULSE = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_TICKS    = 3'd3;
    localparam logic [2:0] CFG_REPORT_EVERY     = 3'd4;

    localparam logic [15:0] RST_PULSES_PER_LITRE = 16'd8453;
    localparam logic [15:0] RST_TARGET_OFFSET    = 16'd15685;
    localparam logic [15:0] RST_LITRES_PER_PULSE = 16'd31758;
    localparam logic [9:0]  RST_TIMEOUT_TICKS    = 10'd100;
    localparam logic [5:0]  RST_REPORT_EVERY     = 6'd10;

    localparam logic [6:0]  PERCENT_FULL  = 7'd100;
    localparam logic [10:0] LITRES_MAX    = 11'd2047;
    localparam logic [9:0]  QUIET_MAX     = 10'd1023;

    localparam logic [1:0] ALU_NOP  = 2'd0;
    localparam logic [1:0] ALU_MUL  = 2'd1;
    localparam logic [1:0] ALU_CSUB = 2'd2;

    typedef struct packed {
        logic [15:0] pulses_per_litre_q12;
        logic [15:0] target_offset_q12;
        logic [15:0] litres_per_pulse_q16;
        logic [9:0]  timeout_ticks;
        logic [5:0]  report_every;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             ge;
    } alu_rsp_t;

endpackage

// ===== sv/flow_metered_dose_controller.sv =====
// Top level of the flow metered dose controller: configuration registers and unit wiring.
//
// One item is worked on at a time and s_tready is low while it is in progress; a result
// waiting in the output register does not hold off the next transfer. All products and
// the percent division run through one shared unit (a 32x16 multiplier and a 40-bit
// compare and subtract); the percent quotient is found in 8 restoring compare and
// subtract steps.
module flow_metered_dose_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // litres_target [9:0], valve_select [10], tick_pulses [18:11], zero fill [23:19]
    input  logic [23:0] s_tdata,
    // cmd [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dosing [0], valve_id [1], report_valid [2], percent_done [9:3], finished [10],
    // end_cause [12:11], litres_delivered [23:13]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    fmdc_pkg::cfg_t     cfg_reg;
    fmdc_pkg::cfg_t     cfg_next;
    fmdc_pkg::alu_req_t alu_req;
    fmdc_pkg::alu_rsp_t alu_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fmdc_pkg::CFG_PULSES_PER_LITRE: cfg_next.pulses_per_litre_q12 = cfg_wdata;
                fmdc_pkg::CFG_TARGET_OFFSET:    cfg_next.target_offset_q12    = cfg_wdata;
                fmdc_pkg::CFG_LITRES_PER_PULSE: cfg_next.litres_per_pulse_q16 = cfg_wdata;
                fmdc_pkg::CFG_TIMEOUT_TICKS:    cfg_next.timeout_ticks = cfg_wdata[9:0];
                fmdc_pkg::CFG_REPORT_EVERY:     cfg_next.report_every  = cfg_wdata[5:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulses_per_litre_q12 <= fmdc_pkg::RST_PULSES_PER_LITRE;
            cfg_reg.target_offset_q12    <= fmdc_pkg::RST_TARGET_OFFSET;
            cfg_reg.litres_per_pulse_q16 <= fmdc_pkg::RST_LITRES_PER_PULSE;
            cfg_reg.timeout_ticks        <= fmdc_pkg::RST_TIMEOUT_TICKS;
            cfg_reg.report_every         <= fmdc_pkg::RST_REPORT_EVERY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fmdc_alu u_alu (
        .clk (clk),
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fmdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .alu_req  (alu_req),
        .alu_rsp  (alu_rsp)
    );

endmodule

// ===== sv/fmdc_alu.sv =====
// Shared arithmetic unit: registered multiply or compare and conditional subtract.
module fmdc_alu (
    input  logic               clk,
    input  fmdc_pkg::alu_req_t req,
    output fmdc_pkg::alu_rsp_t rsp
);

    logic [fmdc_pkg::ALU_W-1:0] y_reg;
    logic [fmdc_pkg::ALU_W-1:0] y_next;
    logic                       ge_reg;
    logic                       ge_next;
    logic [47:0]                prod;
    logic                       ge;

    assign prod = req.a[31:0] * req.b[15:0];
    assign ge   = (req.a >= req.b);

    always_comb
    begin
        y_next  = y_reg;
        ge_next = ge_reg;
        unique case (req.op)
            fmdc_pkg::ALU_MUL:
            begin
                y_next = prod[fmdc_pkg::ALU_W-1:0];
            end
            fmdc_pkg::ALU_CSUB:
            begin
                ge_next = ge;
                y_next  = ge ? (req.a - req.b) : req.a;
            end
            default:
            begin
                y_next = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= y_next;
        ge_reg <= ge_next;
    end

    assign rsp.y  = y_reg;
    assign rsp.ge = ge_reg;

endmodule

// ===== sv/fmdc_ctrl.sv =====
// Sequencer, dose state and output register of the flow metered dose controller.
module fmdc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  fmdc_pkg::cfg_t     cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output fmdc_pkg::alu_req_t alu_req,
    input  fmdc_pkg::alu_rsp_t alu_rsp
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GOAL    = 4'd1;
    localparam logic [3:0] S_SETGOAL = 4'd2;
    localparam logic [3:0] S_APPLY   = 4'd3;
    localparam logic [3:0] S_TICK    = 4'd4;
    localparam logic [3:0] S_MULX    = 4'd5;
    localparam logic [3:0] S_MUL100  = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_DIVEND  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic        running_reg, running_next;
    logic        active_valve_reg, active_valve_next;
    logic [9:0]  litres_goal_reg, litres_goal_next;
    logic [13:0] pulse_goal_reg, pulse_goal_next;
    logic [15:0] pulse_total_reg, pulse_total_next;
    logic [9:0]  quiet_ticks_reg, quiet_ticks_next;
    logic [5:0]  report_ticks_reg, report_ticks_next;

    logic [1:0]  cmd_reg, cmd_next;
    logic [9:0]  litres_reg, litres_next;
    logic        valve_reg, valve_next;
    logic [7:0]  pulses_reg, pulses_next;

    logic        rep_reg, rep_next;
    logic        fin_reg, fin_next;
    logic [1:0]  cause_reg, cause_next;
    logic [6:0]  pct_reg, pct_next;
    logic [10:0] lit_reg, lit_next;
    logic [6:0]  q_reg, q_next;
    logic [2:0]  idx_reg, idx_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    logic        accept;
    logic        load_out;
    logic [13:0] goal;
    logic [16:0] pulse_sum;
    logic [7:0]  q_full;
    logic [25:0] den;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign goal     = alu_rsp.ge ? alu_rsp.y[25:12] : 14'd0;
    assign pulse_sum = {1'b0, pulse_total_reg} + 17'(pulses_reg);
    assign q_full   = {q_reg, alu_rsp.ge};
    assign den      = {litres_goal_reg, 16'd0};

    always_comb
    begin
        state_next        = state_reg;
        running_next      = running_reg;
        active_valve_next = active_valve_reg;
        litres_goal_next  = litres_goal_reg;
        pulse_goal_next   = pulse_goal_reg;
        pulse_total_next  = pulse_total_reg;
        quiet_ticks_next  = quiet_ticks_reg;
        report_ticks_next = report_ticks_reg;
        cmd_next          = cmd_reg;
        litres_next       = litres_reg;
        valve_next        = valve_reg;
        pulses_next       = pulses_reg;
        rep_next          = rep_reg;
        fin_next          = fin_reg;
        cause_next        = cause_reg;
        pct_next          = pct_reg;
        lit_next          = lit_reg;
        q_next            = q_reg;
        idx_next          = idx_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        alu_req.op        = fmdc_pkg::ALU_NOP;
        alu_req.a         = alu_rsp.y;
        alu_req.b         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    litres_next = s_tdata[9:0];
                    valve_next  = s_tdata[10];
                    pulses_next = s_tdata[18:11];
                    rep_next    = 1'b0;
                    fin_next    = 1'b0;
                    cause_next  = fmdc_pkg::CAUSE_TARGET;
                    pct_next    = '0;
                    lit_next    = '0;
                    priority if (s_tuser == fmdc_pkg::CMD_START && !running_reg)
                    begin
                        state_next = S_GOAL;
                    end
                    else if (s_tuser == fmdc_pkg::CMD_TICK && running_reg)
                    begin
                        state_next = S_TICK;
                    end
                    else if (s_tuser == fmdc_pkg::CMD_ABORT && running_reg)
                    begin
                        running_next = 1'b0;
                        fin_next     = 1'b1;
                        cause_next   = fmdc_pkg::CAUSE_ABORT;
                        state_next   = S_MULX;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_GOAL:
            begin
                alu_req.op = fmdc_pkg::ALU_MUL;
                alu_req.a  = fmdc_pkg::ALU_W'(cfg.pulses_per_litre_q12);
                alu_req.b  = fmdc_pkg::ALU_W'(litres_reg);
                state_next = S_SETGOAL;
            end
            S_SETGOAL:
            begin
                alu_req.op = fmdc_pkg::ALU_CSUB;
                alu_req.a  = alu_rsp.y;
                alu_req.b  = fmdc_pkg::ALU_W'(cfg.target_offset_q12);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                active_valve_next = valve_reg;
                litres_goal_next  = litres_reg;
                pulse_goal_next   = goal;
                pulse_total_next  = '0;
                quiet_ticks_next  = '0;
                report_ticks_next = '0;
                if (goal == 14'd0)
                begin
                    fin_next   = 1'b1;
                    cause_next = fmdc_pkg::CAUSE_TARGET;
                end
                else
                begin
                    running_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_TICK:
            begin
                pulse_total_next = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
                if (pulses_reg != 8'd0)
                begin
                    quiet_ticks_next = '0;
                end
                else if (quiet_ticks_reg != fmdc_pkg::QUIET_MAX)
                begin
                    quiet_ticks_next = quiet_ticks_reg + 10'd1;
                end
                if (report_ticks_reg < cfg.report_every)
                begin
                    report_ticks_next = report_ticks_reg + 6'd1;
                end
                else
                begin
                    rep_next          = 1'b1;
                    report_ticks_next = '0;
                end
                state_next = S_MULX;
            end
            S_MULX:
            begin
                if (cmd_reg == fmdc_pkg::CMD_TICK)
                begin
                    priority if (pulse_total_reg >= 16'(pulse_goal_reg))
                    begin
                        fin_next     = 1'b1;
                        cause_next   = fmdc_pkg::CAUSE_TARGET;
                        running_next = 1'b0;
                    end
                    else if (quiet_ticks_reg >= cfg.timeout_ticks)
                    begin
                        fin_next     = 1'b1;
                        cause_next   = fmdc_pkg::CAUSE_TIMEOUT;
                        running_next = 1'b0;
                    end
                end
                alu_req.op = fmdc_pkg::ALU_MUL;
                alu_req.a  = fmdc_pkg::ALU_W'(pulse_total_reg);
                alu_req.b  = fmdc_pkg::ALU_W'(cfg.litres_per_pulse_q16);
                state_next = S_MUL100;
            end
            S_MUL100:
            begin
                if (fin_reg)
                begin
                    lit_next = (alu_rsp.y[31:27] != 5'd0) ? fmdc_pkg::LITRES_MAX
                                                          : alu_rsp.y[26:16];
                end
                if (rep_reg)
                begin
                    alu_req.op = fmdc_pkg::ALU_MUL;
                    alu_req.a  = alu_rsp.y;
                    alu_req.b  = fmdc_pkg::ALU_W'(fmdc_pkg::PERCENT_FULL);
                    idx_next   = 3'd7;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                alu_req.op = fmdc_pkg::ALU_CSUB;
                alu_req.a  = alu_rsp.y;
                alu_req.b  = fmdc_pkg::ALU_W'(den) << idx_reg;
                if (idx_reg != 3'd7)
                begin
                    q_next = {q_reg[5:0], alu_rsp.ge};
                end
                if (idx_reg == 3'd0)
                begin
                    state_next = S_DIVEND;
                end
                else
                begin
                    idx_next = idx_reg - 3'd1;
                end
            end
            S_DIVEND:
            begin
                if (q_full[7] || (q_full[6:0] > fmdc_pkg::PERCENT_FULL))
                begin
                    pct_next = fmdc_pkg::PERCENT_FULL;
                end
                else
                begin
                    pct_next = q_full[6:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {lit_reg, cause_reg, fin_reg, pct_reg, rep_reg,
                                     active_valve_reg, running_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            running_reg      <= 1'b0;
            active_valve_reg <= 1'b0;
            litres_goal_reg  <= '0;
            pulse_goal_reg   <= '0;
            pulse_total_reg  <= '0;
            quiet_ticks_reg  <= '0;
            report_ticks_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_reg      <= running_next;
            active_valve_reg <= active_valve_next;
            litres_goal_reg  <= litres_goal_next;
            pulse_goal_reg   <= pulse_goal_next;
            pulse_total_reg  <= pulse_total_next;
            quiet_ticks_reg  <= quiet_ticks_next;
            report_ticks_reg <= report_ticks_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        litres_reg  <= litres_next;
        valve_reg   <= valve_next;
        pulses_reg  <= pulses_next;
        rep_reg     <= rep_next;
        fin_reg     <= fin_next;
        cause_reg   <= cause_next;
        pct_reg     <= pct_next;
        lit_reg     <= lit_next;
        q_reg       <= q_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_div_only_on_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> rep_reg)
        else $error("division running without a progress report");

    a_finish_stops_dose: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && fin_reg) |-> !running_reg)
        else $error("finished result while the dose still runs");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(running_reg) |-> (pulse_total_reg == 16'd0 && pulse_goal_reg != 14'd0))
        else $error("dose started with stale pulse count or empty goal");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after an input transfer");
`endif

endmodule

// ===== dv/tb_flow_metered_dose_controller.sv =====
// Self-checking testbench of the flow metered dose controller with a built-in dose predictor.
module tb_flow_metered_dose_controller;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int unsigned STALL_LIMIT = 3000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] litres;
        logic       valve;
        logic [7:0] pulses;
    } meter_cmd_t;

    typedef struct packed {
        logic        dosing;
        logic        valve_id;
        logic        report_valid;
        logic [6:0]  percent;
        logic        finished;
        logic [1:0]  cause;
        logic [10:0] litres;
    } meter_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = fmdc_pkg::CFG_PULSES_PER_LITRE;
    logic [15:0] cfg_wdata = '0;

    meter_cmd_t command_queue[$];
    meter_out_t outcome_queue[$];
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned quiet_cycles = 0;
    bit          in_taken = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned ready_count = 0;
    logic [15:0] ready_mask = 16'hffff;

    // Predictor state and register copy.
    fmdc_pkg::cfg_t model_cfg = '{fmdc_pkg::RST_PULSES_PER_LITRE,
                                  fmdc_pkg::RST_TARGET_OFFSET,
                                  fmdc_pkg::RST_LITRES_PER_PULSE,
                                  fmdc_pkg::RST_TIMEOUT_TICKS,
                                  fmdc_pkg::RST_REPORT_EVERY};
    logic        run_q = 1'b0;
    logic        valve_q = 1'b0;
    logic [9:0]  goal_litres = '0;
    logic [13:0] goal_pulses = '0;
    logic [15:0] total_pulses = '0;
    logic [9:0]  quiet_ticks = '0;
    logic [5:0]  report_ticks = '0;

    flow_metered_dose_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic [10:0] litres_so_far();
        logic [63:0] lit;
        lit = (64'(total_pulses) * 64'(model_cfg.litres_per_pulse_q16)) >> 16;
        return (lit > 64'(fmdc_pkg::LITRES_MAX)) ? fmdc_pkg::LITRES_MAX : lit[10:0];
    endfunction

    function automatic meter_out_t meter_step(meter_cmd_t c);
        meter_out_t  r;
        logic [31:0] prod;
        logic [31:0] goal;
        logic [16:0] sum;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        r = '0;
        if (c.cmd == fmdc_pkg::CMD_START && !run_q) begin
            prod = 32'(model_cfg.pulses_per_litre_q12) * 32'(c.litres);
            goal = 32'd0;
            if (prod > 32'(model_cfg.target_offset_q12))
                goal = (prod - 32'(model_cfg.target_offset_q12)) >> 12;
            valve_q = c.valve;
            goal_litres = c.litres;
            goal_pulses = goal[13:0];
            total_pulses = '0;
            quiet_ticks = '0;
            report_ticks = '0;
            if (goal == 32'd0) begin
                r.finished = 1'b1;
                r.cause = fmdc_pkg::CAUSE_TARGET;
            end
            else
                run_q = 1'b1;
        end
        else if (c.cmd == fmdc_pkg::CMD_TICK && run_q) begin
            sum = 17'(total_pulses) + 17'(c.pulses);
            total_pulses = sum[16] ? 16'hffff : sum[15:0];
            if (c.pulses != 8'd0)
                quiet_ticks = '0;
            else if (quiet_ticks < fmdc_pkg::QUIET_MAX)
                quiet_ticks = quiet_ticks + 10'd1;
            if (report_ticks < model_cfg.report_every)
                report_ticks = report_ticks + 6'd1;
            else begin
                r.report_valid = 1'b1;
                report_ticks = '0;
                if (goal_litres == 10'd0)
                    r.percent = fmdc_pkg::PERCENT_FULL;
                else begin
                    num = 64'(total_pulses) * 64'(model_cfg.litres_per_pulse_q16) * 64'd100;
                    den = 64'(goal_litres) << 16;
                    quo = num / den;
                    r.percent = (quo > 64'(fmdc_pkg::PERCENT_FULL)) ? fmdc_pkg::PERCENT_FULL
                                                                    : quo[6:0];
                end
            end
            if (16'(goal_pulses) <= total_pulses) begin
                r.finished = 1'b1;
                r.cause = fmdc_pkg::CAUSE_TARGET;
            end
            else if (quiet_ticks >= model_cfg.timeout_ticks) begin
                r.finished = 1'b1;
                r.cause = fmdc_pkg::CAUSE_TIMEOUT;
            end
            if (r.finished) begin
                run_q = 1'b0;
                r.litres = litres_so_far();
            end
        end
        else if (c.cmd == fmdc_pkg::CMD_ABORT && run_q) begin
            run_q = 1'b0;
            r.finished = 1'b1;
            r.cause = fmdc_pkg::CAUSE_ABORT;
            r.litres = litres_so_far();
        end
        r.dosing = run_q;
        r.valve_id = valve_q;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Scoreboard: output transfers, register writes and input transfers, in that order.
    always @(posedge clk) begin
        meter_out_t want;
        meter_cmd_t c;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (outcome_queue.size() == 0)
                    report_error($sformatf("result 0x%06h with none expected", m_tdata));
                else begin
                    want = outcome_queue.pop_front();
                    check_field("dosing", 32'(m_tdata[0]), 32'(want.dosing));
                    check_field("valve_id", 32'(m_tdata[1]), 32'(want.valve_id));
                    check_field("report_valid", 32'(m_tdata[2]), 32'(want.report_valid));
                    check_field("percent_done", 32'(m_tdata[9:3]), 32'(want.percent));
                    check_field("finished", 32'(m_tdata[10]), 32'(want.finished));
                    check_field("end_cause", 32'(m_tdata[12:11]), 32'(want.cause));
                    check_field("litres_delivered", 32'(m_tdata[23:13]), 32'(want.litres));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    fmdc_pkg::CFG_PULSES_PER_LITRE:
                        model_cfg.pulses_per_litre_q12 = cfg_wdata;
                    fmdc_pkg::CFG_TARGET_OFFSET:
                        model_cfg.target_offset_q12 = cfg_wdata;
                    fmdc_pkg::CFG_LITRES_PER_PULSE:
                        model_cfg.litres_per_pulse_q16 = cfg_wdata;
                    fmdc_pkg::CFG_TIMEOUT_TICKS:
                        model_cfg.timeout_ticks = cfg_wdata[9:0];
                    fmdc_pkg::CFG_REPORT_EVERY:
                        model_cfg.report_every = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                c.cmd = s_tuser;
                c.litres = s_tdata[9:0];
                c.valve = s_tdata[10];
                c.pulses = s_tdata[18:11];
                outcome_queue.push_back(meter_step(c));
                n_accepted++;
            end
            if (in_taken || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Sender: bursts of transfers separated by random gaps.
    always @(negedge clk) begin
        meter_cmd_t c;
        if (rst_n && (!s_tvalid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (command_queue.size() != 0) begin
                c = command_queue.pop_front();
                s_tdata <= {5'b0, c.pulses, c.valve, c.litres};
                s_tuser <= c.cmd;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: a rotating ready mask, replaced at random intervals.
    always @(negedge clk) begin
        if (rst_n) begin
            if (ready_count == 0) begin
                ready_count = $urandom_range(16, 96);
                ready_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                if (ready_mask == 16'h0000)
                    ready_mask = 16'h0001;
            end
            else begin
                ready_count--;
                ready_mask = {ready_mask[14:0], ready_mask[15]};
            end
            m_tready <= ready_mask[0];
        end
    end

    task automatic push_item(logic [1:0] cmd, logic [9:0] litres, logic valve,
                             logic [7:0] pulses);
        meter_cmd_t c;
        c.cmd = cmd;
        c.litres = litres;
        c.valve = valve;
        c.pulses = pulses;
        command_queue.push_back(c);
        n_queued++;
    endtask

    task automatic push_noise();
        push_item(2'($urandom_range(0, 3)), 10'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] ppl, logic [15:0] offset, logic [15:0] lpp,
                                  logic [9:0] timeout, logic [5:0] every);
        write_reg(fmdc_pkg::CFG_PULSES_PER_LITRE, ppl);
        write_reg(fmdc_pkg::CFG_TARGET_OFFSET, offset);
        write_reg(fmdc_pkg::CFG_LITRES_PER_PULSE, lpp);
        write_reg(fmdc_pkg::CFG_TIMEOUT_TICKS, 16'(timeout));
        write_reg(fmdc_pkg::CFG_REPORT_EVERY, 16'(every));
    endtask

    task automatic drain();
        while (n_accepted != n_queued || outcome_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed doses with random content, plus stray and broken commands.
    task automatic add_doses(int unsigned n);
        int unsigned added;
        int unsigned ticks;
        int unsigned rate;
        logic [9:0]  litres;
        logic [7:0]  pulses;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
                added++;
            end
            else begin
                litres = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
                push_item(fmdc_pkg::CMD_START, litres, 1'($urandom), 8'($urandom));
                ticks = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: rate = 0;
                    1: rate = 3;
                    2: rate = 20;
                    default: rate = 255;
                endcase
                for (int unsigned k = 0; k < ticks; k++) begin
                    if ($urandom_range(0, 29) == 0)
                        push_item(fmdc_pkg::CMD_START, 10'($urandom), 1'($urandom),
                                  8'($urandom));
                    pulses = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, rate));
                    push_item(fmdc_pkg::CMD_TICK, 10'($urandom), 1'($urandom), pulses);
                end
                if ($urandom_range(0, 3) == 0)
                    push_item(fmdc_pkg::CMD_ABORT, 10'($urandom), 1'($urandom), 8'($urandom));
                added += ticks + 2;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings.
        push_item(fmdc_pkg::CMD_TICK, 10'd1023, 1'b1, 8'd255);
        push_item(fmdc_pkg::CMD_ABORT, 10'd1023, 1'b1, 8'd255);
        push_item(CMD_NONE, 10'd1023, 1'b1, 8'd255);
        push_item(fmdc_pkg::CMD_START, 10'd0, 1'b1, 8'd0);
        push_item(fmdc_pkg::CMD_START, 10'd2, 1'b0, 8'd0);
        push_item(fmdc_pkg::CMD_START, 10'd3, 1'b1, 8'd0);
        push_item(fmdc_pkg::CMD_START, 10'd500, 1'b0, 8'd0);
        push_item(fmdc_pkg::CMD_TICK, 10'd0, 1'b0, 8'd0);
        push_item(fmdc_pkg::CMD_TICK, 10'd0, 1'b0, 8'd1);
        push_item(fmdc_pkg::CMD_TICK, 10'd0, 1'b0, 8'd1);
        push_item(fmdc_pkg::CMD_START, 10'd1023, 1'b0, 8'd255);
        for (int i = 0; i < 11; i++)
            push_item(fmdc_pkg::CMD_TICK, 10'd0, 1'b0, 8'd100);
        push_item(CMD_NONE, 10'd0, 1'b0, 8'd0);
        push_item(fmdc_pkg::CMD_ABORT, 10'd0, 1'b0, 8'd0);
        drain();

        apply_settings(16'hffff, 16'h0000, 16'hffff, 10'd1023, 6'd0);
        add_doses(80);
        drain();
        apply_settings(16'hffff, 16'hffff, 16'h0000, 10'd0, 6'd63);
        add_doses(70);
        drain();
        apply_settings(16'h0000, 16'h0000, 16'h0001, 10'd1, 6'd1);
        add_doses(25);
        drain();
        for (int p = 0; p < 6; p++) begin
            apply_settings(pick16(), pick16(), pick16(),
                           ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8)),
                           6'($urandom));
            add_doses(85);
            drain();
        end

        repeat (40) @(posedge clk);
        if (outcome_queue.size() != 0)
            report_error($sformatf("%0d results never arrived", outcome_queue.size()));
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== flow_metered_dose_controller.f =====
sv/fmdc_pkg.sv
sv/fmdc_alu.sv
sv/fmdc_ctrl.sv
sv/flow_metered_dose_controller.sv
dv/tb_flow_metered_dose_controller.sv
